// ----- design/wes_pkg.sv -----
// shared types, constants and register codes of the wave-equation stencil step unit
package wes_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_VALUE_BITS = 32;

    localparam int VAL_W     = 32;
    localparam int SPD_W     = 16;
    localparam int GW_W      = 11;
    localparam int GH_W      = 21;
    localparam int ROW_W     = GH_W + 1;
    localparam int COEF_W    = 32;
    localparam int CPART_W   = COEF_W / 2 + 1;
    localparam int LAP_W     = VAL_W + 3;
    localparam int BASE_W    = VAL_W + 2;
    localparam int PROD_W    = CPART_W + LAP_W;
    localparam int A_W       = PROD_W + 2;
    localparam int SPART_W   = SPD_W + 1;
    localparam int PH_W      = A_W + SPART_W;
    localparam int SUM_W     = PH_W + 1;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;
    localparam int IN_DATA_W = 2 * VAL_W + SPD_W;

    localparam logic [GW_W-1:0]   GRID_WIDTH_RST  = GW_W'(640);
    localparam logic [GH_W-1:0]   GRID_HEIGHT_RST = GH_W'(480);
    localparam logic [COEF_W-1:0] COEF_RST        = COEF_W'(1966);

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_COEF_X      = 2'd2,
        REG_COEF_Y      = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_CELL  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef struct packed {
        logic [SPD_W-1:0]        speed;
        logic signed [VAL_W-1:0] prev;
        logic signed [VAL_W-1:0] cur;
    } t_cell;

    typedef struct packed {
        logic res;
        logic has_w;
        logic has_e;
        logic has_n;
        logic has_s;
        logic last;
    } t_flags;

endpackage

// ----- design/wave_equation_stencil_step_unit.sv -----
// top level of the wave-equation stencil step unit: line buffers, window and arithmetic pipeline
//
// One time step of a 2D five-point wave-equation update on cells streamed in raster
// order. The unit takes one request per clock; s_axis_tready drops only when the
// output register and the skid register both hold results. The result for a cell
// leaves grid_width+1 requests after the cell enters, so after the last cell of a
// frame the user sends grid_width+1 more requests (drain requests serve) to flush it;
// tlast marks the frame's final cell. An accepted request's result reaches m_axis
// through the input line buffer read, the centre line buffer read, five arithmetic
// stages and the output register. The line buffers are single-port synchronous
// memories of MAX_WIDTH entries, each accessed once per request at the column
// position; they need no clearing pass, since every entry that reaches a result was
// written earlier in the same frame. Configuration must be written by the user only
// while the unit is idle; the unit itself does not enforce this. A geometry write restarts the frame.
module wave_equation_stencil_step_unit #(
    parameter int MAX_WIDTH  = wes_pkg::DEF_MAX_WIDTH,
    parameter int VALUE_BITS = wes_pkg::DEF_VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // current_value, previous_value, speed
    input  logic [wes_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // next_value
    output logic [wes_pkg::VAL_W-1:0]      m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wes_pkg::APB_AW-1:0]     paddr,
    input  logic [wes_pkg::APB_DW-1:0]     pwdata,
    output logic [wes_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int VW    = wes_pkg::VAL_W;
    localparam int SW    = wes_pkg::SUM_W;
    localparam logic signed [SW-1:0] SAT_MAX =
        signed'((SW'(1) << (VALUE_BITS - 1)) - SW'(1));
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

    // configuration registers
    logic [wes_pkg::GW_W-1:0]   r_grid_width;
    logic [wes_pkg::GH_W-1:0]   r_grid_height;
    logic [wes_pkg::COEF_W-1:0] r_coef_x;
    logic [wes_pkg::COEF_W-1:0] r_coef_y;
    logic                       cfg_wr;
    wes_pkg::t_reg_idx          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = wes_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= wes_pkg::GRID_WIDTH_RST;
            r_grid_height <= wes_pkg::GRID_HEIGHT_RST;
            r_coef_x      <= wes_pkg::COEF_RST;
            r_coef_y      <= wes_pkg::COEF_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                wes_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[wes_pkg::GW_W-1:0];
                wes_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[wes_pkg::GH_W-1:0];
                wes_pkg::REG_COEF_X:      r_coef_x      <= pwdata;
                wes_pkg::REG_COEF_Y:      r_coef_y      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            wes_pkg::REG_GRID_WIDTH:  prdata = wes_pkg::APB_DW'(r_grid_width);
            wes_pkg::REG_GRID_HEIGHT: prdata = wes_pkg::APB_DW'(r_grid_height);
            wes_pkg::REG_COEF_X:      prdata = r_coef_x;
            wes_pkg::REG_COEF_Y:      prdata = r_coef_y;
            default:                  prdata = '0;
        endcase
    end

    // effective geometry
    logic [WB-1:0]               w_eff;
    logic [wes_pkg::GH_W-1:0]    h_eff;

    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = WB'(1);
        end else if (32'(r_grid_width) > 32'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(r_grid_width);
        end
        h_eff = (r_grid_height == '0) ? wes_pkg::GH_W'(1) : r_grid_height;
    end

    // flow control
    logic adv;
    logic acc;
    logic r_sk_valid;

    assign adv           = !r_sk_valid;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;

    // raster position
    logic [COL_W-1:0]         r_col;
    logic [wes_pkg::ROW_W-1:0] r_row;
    logic [wes_pkg::ROW_W-1:0] h_ext;
    logic                     col_nz;
    logic                     row_end;
    wes_pkg::t_flags          flags;
    wes_pkg::t_cell           cell_in;

    assign h_ext   = wes_pkg::ROW_W'(h_eff);
    assign col_nz  = (r_col != '0);
    assign row_end = (WB'(r_col) + WB'(1)) >= w_eff;
    assign cell_in = (s_axis_tuser == wes_pkg::OP_DRAIN) ? '0 : wes_pkg::t_cell'(s_axis_tdata);

    always_comb begin
        flags.res   = col_nz ? (r_row >= wes_pkg::ROW_W'(1)) : (r_row >= wes_pkg::ROW_W'(2));
        flags.has_n = col_nz ? (r_row >= wes_pkg::ROW_W'(2)) : (r_row >= wes_pkg::ROW_W'(3));
        flags.has_s = col_nz ? (r_row < h_ext) : (r_row < h_ext + wes_pkg::ROW_W'(1));
        flags.has_w = (r_col >= COL_W'(2)) || (!col_nz && (w_eff > WB'(1)));
        flags.has_e = col_nz;
        flags.last  = !col_nz && (r_row >= h_ext + wes_pkg::ROW_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (cfg_wr && (cfg_idx == wes_pkg::REG_GRID_WIDTH ||
                                    cfg_idx == wes_pkg::REG_GRID_HEIGHT))) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (flags.last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + wes_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // input line buffer: current, previous and speed delayed by one row
    wes_pkg::t_cell mem_in [MAX_WIDTH];
    wes_pkg::t_cell r_q_in;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q_in       <= mem_in[r_col];
            mem_in[r_col] <= cell_in;
        end
    end

    // stage 1
    logic                    r_v1;
    logic [COL_W-1:0]        r_col1;
    wes_pkg::t_flags         r_f1;
    logic signed [VW-1:0]    r_south1;
    logic signed [VW-1:0]    r_last_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_col1     <= r_col;
            r_f1       <= flags;
            r_south1   <= r_last_cur;
            r_last_cur <= cell_in.cur;
        end
    end

    // window, one-cell delays and centre line buffer
    logic signed [VW-1:0]           r_win1;
    logic signed [VW-1:0]           r_win2;
    logic signed [VW-1:0]           r_pdly;
    logic [wes_pkg::SPD_W-1:0]      r_sdly;
    logic signed [VW-1:0]           mem_ctr [MAX_WIDTH];
    logic signed [VW-1:0]           r_q_n;

    logic                           r_v2;
    wes_pkg::t_flags                r_f2;
    logic signed [VW-1:0]           r_cen2;
    logic signed [VW-1:0]           r_west2;
    logic signed [VW-1:0]           r_east2;
    logic signed [VW-1:0]           r_prev2;
    logic signed [VW-1:0]           r_south2;
    logic [wes_pkg::SPD_W-1:0]      r_spd2;

    always_ff @(posedge i_clk) begin
        if (adv && r_v1) begin
            r_win1          <= r_win2;
            r_win2          <= r_q_in.cur;
            r_pdly          <= r_q_in.prev;
            r_sdly          <= r_q_in.speed;
            r_q_n           <= mem_ctr[r_col1];
            mem_ctr[r_col1] <= r_win2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f2     <= r_f1;
            r_cen2   <= r_win2;
            r_west2  <= r_win1;
            r_east2  <= r_q_in.cur;
            r_prev2  <= r_pdly;
            r_south2 <= r_south1;
            r_spd2   <= r_sdly;
        end
    end

    // stage 3: laplacian terms, base term and speed squared
    logic signed [VW-1:0]             west;
    logic signed [VW-1:0]             east;
    logic signed [VW-1:0]             north;
    logic signed [VW-1:0]             south;
    logic signed [wes_pkg::LAP_W-1:0] lap_x;
    logic signed [wes_pkg::LAP_W-1:0] lap_y;
    logic signed [wes_pkg::LAP_W-1:0] two_c;
    logic signed [wes_pkg::BASE_W-1:0] base;
    logic [wes_pkg::COEF_W-1:0]       s2;

    assign west  = r_f2.has_w ? r_west2  : '0;
    assign east  = r_f2.has_e ? r_east2  : '0;
    assign north = r_f2.has_n ? r_q_n    : '0;
    assign south = r_f2.has_s ? r_south2 : '0;
    assign two_c = wes_pkg::LAP_W'(r_cen2) <<< 1;
    assign lap_x = wes_pkg::LAP_W'(west) + wes_pkg::LAP_W'(east) - two_c;
    assign lap_y = wes_pkg::LAP_W'(north) + wes_pkg::LAP_W'(south) - two_c;
    assign base  = (wes_pkg::BASE_W'(r_cen2) <<< 1) - wes_pkg::BASE_W'(r_prev2);
    assign s2    = wes_pkg::COEF_W'(r_spd2) * wes_pkg::COEF_W'(r_spd2);

    logic                              r_v3;
    logic                              r_last3;
    logic signed [wes_pkg::LAP_W-1:0]  r_lapx3;
    logic signed [wes_pkg::LAP_W-1:0]  r_lapy3;
    logic signed [wes_pkg::BASE_W-1:0] r_base3;
    logic [wes_pkg::COEF_W-1:0]        r_s2_3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_last3 <= r_f2.last;
            r_lapx3 <= lap_x;
            r_lapy3 <= lap_y;
            r_base3 <= base;
            r_s2_3  <= s2;
        end
    end

    // stage 4: coefficient products, coefficients split in halves
    logic signed [wes_pkg::CPART_W-1:0] cx_hi;
    logic signed [wes_pkg::CPART_W-1:0] cx_lo;
    logic signed [wes_pkg::CPART_W-1:0] cy_hi;
    logic signed [wes_pkg::CPART_W-1:0] cy_lo;
    logic signed [wes_pkg::PROD_W-1:0]  pxh;
    logic signed [wes_pkg::PROD_W-1:0]  pxl;
    logic signed [wes_pkg::PROD_W-1:0]  pyh;
    logic signed [wes_pkg::PROD_W-1:0]  pyl;

    assign cx_hi = signed'({1'b0, r_coef_x[wes_pkg::COEF_W-1:wes_pkg::COEF_W/2]});
    assign cx_lo = signed'({1'b0, r_coef_x[wes_pkg::COEF_W/2-1:0]});
    assign cy_hi = signed'({1'b0, r_coef_y[wes_pkg::COEF_W-1:wes_pkg::COEF_W/2]});
    assign cy_lo = signed'({1'b0, r_coef_y[wes_pkg::COEF_W/2-1:0]});
    assign pxh   = cx_hi * r_lapx3;
    assign pxl   = cx_lo * r_lapx3;
    assign pyh   = cy_hi * r_lapy3;
    assign pyl   = cy_lo * r_lapy3;

    logic                              r_v4;
    logic                              r_last4;
    logic signed [wes_pkg::PROD_W-1:0] r_pxh4;
    logic signed [wes_pkg::PROD_W-1:0] r_pxl4;
    logic signed [wes_pkg::PROD_W-1:0] r_pyh4;
    logic signed [wes_pkg::PROD_W-1:0] r_pyl4;
    logic signed [wes_pkg::BASE_W-1:0] r_base4;
    logic [wes_pkg::COEF_W-1:0]        r_s2_4;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_last4 <= r_last3;
            r_pxh4  <= pxh;
            r_pxl4  <= pxl;
            r_pyh4  <= pyh;
            r_pyl4  <= pyl;
            r_base4 <= r_base3;
            r_s2_4  <= r_s2_3;
        end
    end

    // stage 5: weighted laplacian sum
    logic signed [wes_pkg::A_W-1:0] acc_a;

    assign acc_a = wes_pkg::A_W'(r_pxh4) + wes_pkg::A_W'(r_pxl4 >>> 16)
                 + wes_pkg::A_W'(r_pyh4) + wes_pkg::A_W'(r_pyl4 >>> 16);

    logic                              r_v5;
    logic                              r_last5;
    logic signed [wes_pkg::A_W-1:0]    r_a5;
    logic signed [wes_pkg::BASE_W-1:0] r_base5;
    logic [wes_pkg::COEF_W-1:0]        r_s2_5;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_last5 <= r_last4;
            r_a5    <= acc_a;
            r_base5 <= r_base4;
            r_s2_5  <= r_s2_4;
        end
    end

    // stage 6: speed squared products, speed squared split in halves
    logic signed [wes_pkg::SPART_W-1:0] s_hi;
    logic signed [wes_pkg::SPART_W-1:0] s_lo;
    logic signed [wes_pkg::PH_W-1:0]    ph;
    logic signed [wes_pkg::PH_W-1:0]    pl;

    assign s_hi = signed'({1'b0, r_s2_5[wes_pkg::COEF_W-1:wes_pkg::COEF_W/2]});
    assign s_lo = signed'({1'b0, r_s2_5[wes_pkg::COEF_W/2-1:0]});
    assign ph   = r_a5 * s_hi;
    assign pl   = r_a5 * s_lo;

    logic                              r_v6;
    logic                              r_last6;
    logic signed [wes_pkg::PH_W-1:0]   r_ph6;
    logic signed [wes_pkg::PH_W-1:0]   r_pl6;
    logic signed [wes_pkg::BASE_W-1:0] r_base6;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_last6 <= r_last5;
            r_ph6   <= ph;
            r_pl6   <= pl;
            r_base6 <= r_base5;
        end
    end

    // stage 7: full sum
    logic signed [SW-1:0] sum;

    assign sum = SW'(r_ph6) + SW'(r_pl6 >>> 16) + SW'(r_base6);

    logic                 r_v7;
    logic                 r_last7;
    logic signed [SW-1:0] r_sum7;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_last7 <= r_last6;
            r_sum7  <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1 && r_f1.res;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // saturation and output with skid
    logic signed [SW-1:0] sat;
    logic [VW-1:0]        res;

    always_comb begin
        if (r_sum7 > SAT_MAX) begin
            sat = SAT_MAX;
        end else if (r_sum7 < SAT_MIN) begin
            sat = SAT_MIN;
        end else begin
            sat = r_sum7;
        end
    end

    assign res = sat[VW-1:0];

    logic          r_out_valid;
    logic [VW-1:0] r_out_data;
    logic          r_out_last;
    logic [VW-1:0] r_sk_data;
    logic          r_sk_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (m_axis_tready) begin
                r_out_data <= r_sk_data;
                r_out_last <= r_sk_last;
                r_sk_valid <= 1'b0;
            end
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_v7;
            r_out_data  <= res;
            r_out_last  <= r_last7;
        end else if (r_v7) begin
            r_sk_valid <= 1'b1;
            r_sk_data  <= res;
            r_sk_last  <= r_last7;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- design/wes_checker.sv -----
// port-level checks of the wave-equation stencil step unit and their binding
module wes_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    // next_value
    input logic [wes_pkg::VAL_W-1:0]      m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [wes_pkg::APB_AW-1:0]     paddr,
    input logic [wes_pkg::APB_DW-1:0]     pwdata,
    input logic [wes_pkg::APB_DW-1:0]     prdata,
    input logic                           pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // input back-pressure only while a result is waiting
    a_bp_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // input back-pressure only after the output stalled
    a_bp_after_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    // x coefficient write reads back
    a_coef_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[3:2] == wes_pkg::REG_COEF_X) |=>
            (paddr[3:2] != wes_pkg::REG_COEF_X) || (prdata == $past(pwdata)))
        else $error("coefficient readback mismatch");

endmodule

bind wave_equation_stencil_step_unit wes_checker u_wes_checker (.*);
